@@ design/zcd_pkg.sv @@
// zcd_pkg: shared constants, register indexes and the seven-segment font
// for the zoned clock display block; no dependencies
package zcd_pkg;

  // timing constants
  localparam int TICKS_PER_SECOND = 1000;
  localparam int SCAN_PERIOD      = 20;
  localparam int DIGIT_CYCLE      = 10;
  localparam int ZONES            = 4;

  // field widths
  localparam int MILLIS_W = $clog2(TICKS_PER_SECOND);
  localparam int SCAN_W   = (SCAN_PERIOD > 1) ? $clog2(SCAN_PERIOD) : 1;
  localparam int PHASE_W  = $clog2(DIGIT_CYCLE);
  localparam int ZONE_W   = 2;
  localparam int OFF_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int KEYS     = 12;
  localparam int KEY_W    = 4;

  // time limits
  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;

  // key code for no single key pressed
  localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(KEYS);

  // request kinds
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_SETTIME = 1'b1;

  // configuration register indexes
  localparam logic [ZONE_W-1:0] REG_ZONE0_OFFSET = 2'd0;
  localparam logic [ZONE_W-1:0] REG_ZONE1_OFFSET = 2'd1;
  localparam logic [ZONE_W-1:0] REG_ZONE2_OFFSET = 2'd2;
  localparam logic [ZONE_W-1:0] REG_ZONE3_OFFSET = 2'd3;

  // digit phases inside the multiplex cycle
  localparam logic [PHASE_W-1:0] PH_ZONE      = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_HOUR_TENS = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_HOUR_ONES = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] PH_MIN_TENS  = PHASE_W'(6);
  localparam logic [PHASE_W-1:0] PH_MIN_ONES  = PHASE_W'(8);

  // active-low digit selects
  localparam logic [4:0] DIG_NONE      = 5'b11111;
  localparam logic [4:0] DIG_ZONE      = 5'b01111;
  localparam logic [4:0] DIG_HOUR_TENS = 5'b10111;
  localparam logic [4:0] DIG_HOUR_ONES = 5'b11011;
  localparam logic [4:0] DIG_MIN_TENS  = 5'b11101;
  localparam logic [4:0] DIG_MIN_ONES  = 5'b11110;

  localparam logic [7:0] DP_BIT = 8'h80;

  function automatic logic [7:0] seg_font(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

@@ design/zoned_clock_display_keypad_tick.sv @@
// zoned_clock_display_keypad_tick: millisecond clock with time zones,
// keypad latch and five-digit multiplexed display; uses zcd_pkg
// result: registered, a beat's result shows in the cycle after it is accepted
// throughput: one beat per cycle while the result is drained, set by the single time/display register stage
// the result register is the clock state itself; a stalled result stops input
// reset (async, active low): time 00:00:00 stopped, no key (code 12), all digits
// off, zone offsets zero
module zoned_clock_display_keypad_tick
  import zcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [ZONE_W-1:0]   cfg_idx_i,
  input  logic [OFF_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [HOUR_W-1:0]   new_hour_i,
  input  logic [MIN_W-1:0]    new_minute_i,
  input  logic [KEYS-1:0]     key_sample_i,
  input  logic [ZONE_W-1:0]   zone_select_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          digit_select_n_o,
  output logic [7:0]          segments_o,
  output logic [KEY_W-1:0]    key_code_o,
  output logic                key_valid_o
);

  // clock state
  logic [MILLIS_W-1:0] millis_q, millis_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;     // millis modulo scan period
  logic [PHASE_W-1:0]  phase_q, phase_d;   // millis modulo digit cycle
  logic [MIN_W-1:0]    seconds_q, seconds_d;
  logic [MIN_W-1:0]    minutes_q, minutes_d;
  logic [HOUR_W-1:0]   hours_q, hours_d;
  logic                running_q, running_d;

  // keypad and display registers
  logic [KEY_W-1:0]    key_q, key_d;
  logic                key_vld_q, key_vld_d;
  logic [4:0]          digit_q, digit_d;
  logic [7:0]          seg_q, seg_d;

  logic                out_valid_q;
  logic [OFF_W-1:0]    zone_off_q [ZONES];

  logic                in_acc;
  logic                ms_wrap;

  // display helpers
  logic [ZONE_W-1:0]   zone_sel;
  logic [OFF_W:0]      hz_sum;
  logic [HOUR_W-1:0]   hz;
  logic [3:0]          hz_tens, hz_ones;
  logic [3:0]          mn_tens, mn_ones;
  logic [3:0]          zone_digit;

  // keypad decode
  logic                one_key;
  logic [KEY_W-1:0]    key_idx;

  // the result register frees up when empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign out_valid_o      = out_valid_q;
  assign digit_select_n_o = digit_q;
  assign segments_o       = seg_q;
  assign key_code_o       = key_q;
  assign key_valid_o      = key_vld_q;

  // single-key detect: nonzero with no second bit set
  always_comb begin
    key_idx = NO_KEY;
    for (int b = 0; b < KEYS; b++) begin
      if (key_sample_i[b]) begin
        key_idx = KEY_W'(b);
      end
    end
    one_key = (key_sample_i != '0) &&
              ((key_sample_i & (key_sample_i - KEYS'(1))) == '0);
  end

  // time and counters
  always_comb begin
    millis_d  = millis_q;
    scan_d    = scan_q;
    phase_d   = phase_q;
    seconds_d = seconds_q;
    minutes_d = minutes_q;
    hours_d   = hours_q;
    running_d = running_q;
    ms_wrap   = (millis_q == MILLIS_W'(TICKS_PER_SECOND - 1));

    if (in_acc) begin
      if (req_type_i == REQ_SETTIME) begin
        // load time, saturating out-of-range values, and start counting
        hours_d   = (new_hour_i > HOUR_W'(HOUR_PER_DAY - 1)) ?
                    HOUR_W'(HOUR_PER_DAY - 1) : new_hour_i;
        minutes_d = (new_minute_i > MIN_W'(MIN_PER_HOUR - 1)) ?
                    MIN_W'(MIN_PER_HOUR - 1) : new_minute_i;
        millis_d  = '0;
        scan_d    = '0;
        phase_d   = '0;
        running_d = 1'b1;
      end else begin
        // millis counts even when the clock is stopped
        millis_d = ms_wrap ? '0 : millis_q + MILLIS_W'(1);
        scan_d   = (ms_wrap || scan_q == SCAN_W'(SCAN_PERIOD - 1)) ?
                   '0 : scan_q + SCAN_W'(1);
        phase_d  = (ms_wrap || phase_q == PHASE_W'(DIGIT_CYCLE - 1)) ?
                   '0 : phase_q + PHASE_W'(1);
        if (ms_wrap && running_q) begin
          if (seconds_q == MIN_W'(SEC_PER_MIN - 1)) begin
            seconds_d = '0;
            if (minutes_q == MIN_W'(MIN_PER_HOUR - 1)) begin
              minutes_d = '0;
              hours_d   = (hours_q == HOUR_W'(HOUR_PER_DAY - 1)) ?
                          '0 : hours_q + HOUR_W'(1);
            end else begin
              minutes_d = minutes_q + MIN_W'(1);
            end
          end else begin
            seconds_d = seconds_q + MIN_W'(1);
          end
        end
      end
    end
  end

  // digit values from the updated time
  always_comb begin
    // zones past the last one show and use the last one
    zone_sel = (zone_select_i > ZONE_W'(ZONES - 1)) ? ZONE_W'(ZONES - 1) : zone_select_i;

    // hours + offset is at most 54, so two conditional subtracts reduce it
    hz_sum = {1'b0, hours_d} + {1'b0, zone_off_q[zone_sel]};
    if (hz_sum >= (OFF_W+1)'(2 * HOUR_PER_DAY)) begin
      hz = HOUR_W'(hz_sum - (OFF_W+1)'(2 * HOUR_PER_DAY));
    end else if (hz_sum >= (OFF_W+1)'(HOUR_PER_DAY)) begin
      hz = HOUR_W'(hz_sum - (OFF_W+1)'(HOUR_PER_DAY));
    end else begin
      hz = HOUR_W'(hz_sum);
    end

    if (hz >= HOUR_W'(20)) begin
      hz_tens = 4'd2;
      hz_ones = 4'(hz - HOUR_W'(20));
    end else if (hz >= HOUR_W'(10)) begin
      hz_tens = 4'd1;
      hz_ones = 4'(hz - HOUR_W'(10));
    end else begin
      hz_tens = 4'd0;
      hz_ones = 4'(hz);
    end

    // minutes stay below 60: five compares give the tens digit
    mn_tens = 4'd0;
    for (int t = 1; t < 6; t++) begin
      if (minutes_d >= MIN_W'(10 * t)) begin
        mn_tens = 4'(t);
      end
    end
    mn_ones = 4'(minutes_d - MIN_W'(10 * mn_tens));

    zone_digit = 4'(zone_sel) + 4'(running_q);
  end

  // keypad latch and display drive, tick beats only
  always_comb begin
    key_d     = key_q;
    key_vld_d = key_vld_q;
    digit_d   = digit_q;
    seg_d     = seg_q;
    if (in_acc && req_type_i == REQ_TICK) begin
      if (scan_d == '0) begin
        key_d     = one_key ? key_idx : NO_KEY;
        key_vld_d = one_key;
      end
      // odd phases hold the display
      case (phase_d)
        PH_ZONE: begin
          digit_d = DIG_ZONE;
          seg_d   = seg_font(zone_digit);
        end
        PH_HOUR_TENS: begin
          digit_d = DIG_HOUR_TENS;
          seg_d   = seg_font(hz_tens);
        end
        PH_HOUR_ONES: begin
          digit_d = DIG_HOUR_ONES;
          seg_d   = seg_font(hz_ones) | DP_BIT;
        end
        PH_MIN_TENS: begin
          digit_d = DIG_MIN_TENS;
          seg_d   = seg_font(mn_tens);
        end
        PH_MIN_ONES: begin
          digit_d = DIG_MIN_ONES;
          seg_d   = seg_font(mn_ones);
        end
        default: begin
          digit_d = digit_q;
          seg_d   = seg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      millis_q    <= '0;
      scan_q      <= '0;
      phase_q     <= '0;
      seconds_q   <= '0;
      minutes_q   <= '0;
      hours_q     <= '0;
      running_q   <= 1'b0;
      key_q       <= NO_KEY;
      key_vld_q   <= 1'b0;
      digit_q     <= DIG_NONE;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      millis_q    <= millis_d;
      scan_q      <= scan_d;
      phase_q     <= phase_d;
      seconds_q   <= seconds_d;
      minutes_q   <= minutes_d;
      hours_q     <= hours_d;
      running_q   <= running_d;
      key_q       <= key_d;
      key_vld_q   <= key_vld_d;
      digit_q     <= digit_d;
      seg_q       <= seg_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // zone offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < ZONES; z++) begin
        zone_off_q[z] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ZONE0_OFFSET: zone_off_q[0] <= cfg_wdata_i;
        REG_ZONE1_OFFSET: zone_off_q[1] <= cfg_wdata_i;
        REG_ZONE2_OFFSET: zone_off_q[2] <= cfg_wdata_i;
        REG_ZONE3_OFFSET: zone_off_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // time of day and counters stay in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hours_q < HOUR_W'(HOUR_PER_DAY) && minutes_q < MIN_W'(MIN_PER_HOUR) &&
    seconds_q < MIN_W'(SEC_PER_MIN) && millis_q < MILLIS_W'(TICKS_PER_SECOND))
    else $error("clock state out of range");

  // scan and digit phase counters stay aligned
  a_phase_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SCAN_W+1)'(scan_q) == (SCAN_W+1)'(phase_q) ||
    (SCAN_W+1)'(scan_q) == (SCAN_W+1)'(phase_q) + (SCAN_W+1)'(DIGIT_CYCLE))
    else $error("scan and digit phase disagree");

  // key flag and code agree
  a_key_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_vld_q ? (key_q < NO_KEY) : (key_q == NO_KEY))
    else $error("key code and valid flag disagree");

  // at most one digit driven
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(~digit_q))
    else $error("more than one digit selected");

  // a set-time beat restarts the millisecond count and runs the clock
  a_settime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == REQ_SETTIME |=> millis_q == '0 && running_q)
    else $error("set time did not restart the clock");
`endif

endmodule

@@ test/testbench.sv @@
// testbench: self-checking bench for zoned_clock_display_keypad_tick
// handshaked driver and monitor, a beat-level clock/keypad/display predictor;
// depends on zcd_pkg and the block itself
module testbench;
  import zcd_pkg::*;

  // run limits and the one long receiver hold-off
  localparam int LIMIT_CYCLES  = 600000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BEATS  = 44;     // per random phase, five phases
  localparam int SOAK_TICKS    = 1010;   // enough for one millisecond wrap while running

  // seven-segment glyphs 0..9, digit d at bits 8*d +: 8
  localparam logic [79:0] GLYPHS = 80'h6F_7F_07_7D_6D_66_4F_5B_06_3F;

  // one request beat and one display/keypad beat
  typedef struct packed {
    logic              kind;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [KEYS-1:0]   keys;
    logic [ZONE_W-1:0] zone;
  } beat_t;

  typedef struct packed {
    logic [4:0]       sel;
    logic [7:0]       seg;
    logic [KEY_W-1:0] code;
    logic             hit;
  } shown_t;

  // clock, reset and block ports, all known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [ZONE_W-1:0] cfg_idx_i     = '0;
  logic [OFF_W-1:0]  cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              req_type_i    = REQ_TICK;
  logic [HOUR_W-1:0] new_hour_i    = '0;
  logic [MIN_W-1:0]  new_minute_i  = '0;
  logic [KEYS-1:0]   key_sample_i  = '0;
  logic [ZONE_W-1:0] zone_select_i = '0;
  logic              out_ready_i   = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [4:0]        digit_select_n_o;
  logic [7:0]        segments_o;
  logic [KEY_W-1:0]  key_code_o;
  logic              key_valid_o;

  zoned_clock_display_keypad_tick u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .new_hour_i      (new_hour_i),
    .new_minute_i    (new_minute_i),
    .key_sample_i    (key_sample_i),
    .zone_select_i   (zone_select_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digit_select_n_o(digit_select_n_o),
    .segments_o      (segments_o),
    .key_code_o      (key_code_o),
    .key_valid_o     (key_valid_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted clock state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  int         tod_ms   = 0;
  int         tod_sec  = 0;
  int         tod_min  = 0;
  int         tod_hour = 0;
  bit         tod_run  = 1'b0;
  int         kp_code  = NO_KEY;
  bit         kp_hit   = 1'b0;
  logic [4:0] disp_sel = DIG_NONE;
  logic [7:0] disp_seg = '0;
  int         zone_ofs [ZONES] = '{default: 0};

  // bench bookkeeping
  beat_t  pending [$];       // beats waiting for the driver
  shown_t expect_q [$];      // predicted results in order of acceptance
  beat_t  on_wire;           // beat currently offered on the request port
  int     send_gap     = 0;
  int     recv_gap     = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     want_hold    = 1'b0;
  bit     hold_taken   = 1'b0;
  int     hold_left    = 0;
  int     cycles       = 0;
  int     mismatches   = 0;
  int     beats_sent   = 0;
  int     set_beats    = 0;
  int     results_seen = 0;
  int     input_stalls = 0;
  int     key_latches  = 0;
  int     day_wraps    = 0;

  // advance the predicted clock by one accepted beat, return what it shows
  function automatic shown_t clock_step(input beat_t b);
    int     z;
    int     hz;
    int     mn;
    int     phase;
    int     hits;
    int     last;
    shown_t r;
    z = int'(b.zone);
    if (z >= ZONES) z = ZONES - 1;
    if (b.kind == REQ_SETTIME) begin
      // seconds survive a set, no scan and no display update
      tod_hour = (b.hour > HOUR_PER_DAY - 1) ? HOUR_PER_DAY - 1 : int'(b.hour);
      tod_min  = (b.minute > MIN_PER_HOUR - 1) ? MIN_PER_HOUR - 1 : int'(b.minute);
      tod_ms   = 0;
      tod_run  = 1'b1;
      set_beats++;
    end else begin
      // millis counts even while stopped
      tod_ms++;
      if (tod_ms >= TICKS_PER_SECOND) begin
        tod_ms = 0;
        if (tod_run) tod_sec++;
      end
      if (tod_run && tod_sec >= SEC_PER_MIN) begin
        tod_sec = 0;
        tod_min++;
        if (tod_min >= MIN_PER_HOUR) begin
          tod_min = 0;
          tod_hour++;
          if (tod_hour >= HOUR_PER_DAY) begin
            tod_hour = 0;
            day_wraps++;
          end
        end
      end
      // keypad scan: a lone key latches, anything else clears
      if (tod_ms % SCAN_PERIOD == 0) begin
        hits = $countones(b.keys);
        last = NO_KEY;
        for (int i = 0; i < KEYS; i++) begin
          if (b.keys[i]) last = i;
        end
        kp_hit  = (hits == 1);
        kp_code = (hits == 1) ? last : NO_KEY;
        if (hits == 1) key_latches++;
      end
      // display multiplex, odd phases hold
      hz    = (tod_hour + zone_ofs[z]) % HOUR_PER_DAY;
      mn    = tod_min % MIN_PER_HOUR;
      phase = tod_ms % DIGIT_CYCLE;
      case (phase)
        PH_ZONE: begin
          disp_sel = DIG_ZONE;
          disp_seg = GLYPHS[8 * ((z + int'(tod_run)) % 10) +: 8];
        end
        PH_HOUR_TENS: begin
          disp_sel = DIG_HOUR_TENS;
          disp_seg = GLYPHS[8 * (hz / 10) +: 8];
        end
        PH_HOUR_ONES: begin
          disp_sel = DIG_HOUR_ONES;
          disp_seg = GLYPHS[8 * (hz % 10) +: 8] | DP_BIT;
        end
        PH_MIN_TENS: begin
          disp_sel = DIG_MIN_TENS;
          disp_seg = GLYPHS[8 * (mn / 10) +: 8];
        end
        PH_MIN_ONES: begin
          disp_sel = DIG_MIN_ONES;
          disp_seg = GLYPHS[8 * (mn % 10) +: 8];
        end
        default: ;
      endcase
    end
    r.sel  = disp_sel;
    r.seg  = disp_seg;
    r.code = KEY_W'(kp_code);
    r.hit  = kp_hit;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers pending beats, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expect_q.push_back(clock_step(on_wire));
        beats_sent++;
      end
      if (in_valid_i && !in_ready_o) input_stalls++;
      // a new beat goes out only once the current one is gone
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(99) < send_idle_pct) begin
          // random burst of idle cycles, this one included
          send_gap = $urandom_range(16, 0);
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0) begin
          on_wire = pending.pop_front();
          req_type_i    <= on_wire.kind;
          new_hour_i    <= on_wire.hour;
          new_minute_i  <= on_wire.minute;
          key_sample_i  <= on_wire.keys;
          zone_select_i <= on_wire.zone;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    shown_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expect_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expect_q.pop_front();
          if (digit_select_n_o !== want.sel)
            flag_mismatch($sformatf("result %0d: digit select %b, expected %b",
                                    results_seen, digit_select_n_o, want.sel));
          if (segments_o !== want.seg)
            flag_mismatch($sformatf("result %0d: segments %h, expected %h",
                                    results_seen, segments_o, want.seg));
          if (key_code_o !== want.code)
            flag_mismatch($sformatf("result %0d: key code %0d, expected %0d",
                                    results_seen, key_code_o, want.code));
          if (key_valid_o !== want.hit)
            flag_mismatch($sformatf("result %0d: key valid %b, expected %b",
                                    results_seen, key_valid_o, want.hit));
        end
      end
      // the long hold-off wins over the random stall bursts
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        recv_gap = $urandom_range(16, 0);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // one long receiver hold-off, counted here so the sender keeps pushing
  always @(posedge clk_i) begin : hold_off
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (want_hold && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expect_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic beat_t mk(input logic kind, input int hour, input int minute,
                               input int keys, input int zone);
    beat_t b;
    b.kind   = kind;
    b.hour   = HOUR_W'(hour);
    b.minute = MIN_W'(minute);
    b.keys   = KEYS'(keys);
    b.zone   = ZONE_W'(zone);
    return b;
  endfunction

  // mostly lone keys so the latch sees real codes, plus empty, chords and noise
  function automatic int key_pattern();
    int k;
    case ($urandom_range(9))
      0, 1, 2, 3: k = 1 << $urandom_range(KEYS - 1);
      4:          k = 0;
      5:          k = (1 << $urandom_range(KEYS - 1)) | (1 << $urandom_range(KEYS - 1));
      default:    k = $urandom_range(4095);
    endcase
    return k;
  endfunction

  // mostly ticks with an occasional set, including out-of-range set values
  function automatic beat_t random_beat();
    logic kind;
    kind = ($urandom_range(99) < 3) ? REQ_SETTIME : REQ_TICK;
    return mk(kind, $urandom_range(31), $urandom_range(63), key_pattern(),
              $urandom_range(3));
  endfunction

  // wait for everything offered to be accepted and checked
  task automatic drain();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || expect_q.size() != 0);
  endtask

  // block is idle here, so the predictor takes the new offset at once
  task automatic write_offset(input logic [ZONE_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= OFF_W'(value);
    zone_ofs[idx] = value & 31;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_offsets(input int o0, input int o1, input int o2, input int o3);
    write_offset(REG_ZONE0_OFFSET, o0);
    write_offset(REG_ZONE1_OFFSET, o1);
    write_offset(REG_ZONE2_OFFSET, o2);
    write_offset(REG_ZONE3_OFFSET, o3);
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (RANDOM_BEATS) pending.push_back(random_beat());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: offsets at zero, top of range, beyond range and mid
    load_offsets(0, 23, 31, 12);
    send_idle_pct = 10;
    recv_idle_pct = 10;
    // stopped clock: display holds on the first odd phase, then hour tens
    pending.push_back(mk(REQ_TICK, 0, 0, 'h000, 0));
    pending.push_back(mk(REQ_TICK, 31, 63, 'hFFF, 1));
    pending.push_back(mk(REQ_TICK, 0, 0, 'h800, 3));
    // set with hour and minute above range, saturates to 23:59
    pending.push_back(mk(REQ_SETTIME, 31, 63, 'h001, 2));
    // one full multiplex cycle, every zone and lone keys
    for (int i = 0; i < 10; i++)
      pending.push_back(mk(REQ_TICK, i, i, 1 << i, i % 4));
    // midnight set, then large offsets wrap modulo a day
    pending.push_back(mk(REQ_SETTIME, 0, 0, 'hFFF, 2));
    for (int i = 0; i < 5; i++)
      pending.push_back(mk(REQ_TICK, 0, 0, 'h400, 2));
    pending.push_back(mk(REQ_SETTIME, 23, 59, 'h000, 3));
    for (int i = 0; i < 4; i++)
      pending.push_back(mk(REQ_TICK, 23, 59, 'h003, 3));
    drain();

    // random phases under different offsets and idling
    load_offsets(0, 0, 0, 0);
    random_phase(15, 15);

    // all offsets at the field maximum; receiver holds off while the
    // sender streams, so the block backs up and stalls its input
    load_offsets(31, 31, 31, 31);
    want_hold = 1'b1;
    random_phase(0, 20);

    load_offsets(23, 23, 23, 23);
    random_phase(20, 0);

    load_offsets($urandom_range(31), $urandom_range(31), $urandom_range(31),
                 $urandom_range(31));
    random_phase(10, 10);

    load_offsets($urandom_range(31), $urandom_range(31), $urandom_range(31),
                 $urandom_range(31));
    random_phase(25, 25);

    // last part, no idling: run from 23:59 past a millisecond wrap so seconds advance
    load_offsets($urandom_range(23), $urandom_range(31), 0, 23);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pending.push_back(mk(REQ_SETTIME, 23, 59, key_pattern(), $urandom_range(3)));
    repeat (SOAK_TICKS)
      pending.push_back(mk(REQ_TICK, $urandom_range(31), $urandom_range(63),
                           key_pattern(), $urandom_range(3)));
    drain();

    // let any stray result show up before the verdict
    repeat (8) @(negedge clk_i);

    $display("run covered %0d beats (%0d time sets), %0d results checked, %0d stalled input cycles",
             beats_sent, set_beats, results_seen, input_stalls);
    $display("single-key latches %0d, midnight wraps %0d, mismatches %0d",
             key_latches, day_wraps, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ zoned_clock_display_keypad_tick.f @@
design/zcd_pkg.sv
design/zoned_clock_display_keypad_tick.sv
test/testbench.sv
